// ===== sv/srv_pkg.sv =====
// Shared types, constants and helpers of the Schroeder reverb core.
`default_nettype none
package srv_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int NUM_LINES   = 7;
    localparam int NUM_COMBS   = 4;
    localparam int PTR_BITS    = 12;
    localparam int LINE_BITS   = 3;
    localparam int SAT_BITS    = 48;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 17;

    // comb a..d, then allpass a..c
    localparam int LINE_DEPTH [NUM_LINES] = '{1730, 1494, 2022, 2246, 250, 84, 24};
    localparam int CLEAR_LEN = 2246;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DELAY_SCALE = 3'd0,
        CFG_WET_MIX     = 3'd1,
        CFG_COMB_GAIN_A = 3'd2,
        CFG_COMB_GAIN_B = 3'd3,
        CFG_COMB_GAIN_C = 3'd4,
        CFG_COMB_GAIN_D = 3'd5,
        CFG_AP_GAIN     = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_COMB_MUL,
        OP_COMB_WR,
        OP_AVG,
        OP_AP_MULX,
        OP_AP_SUB,
        OP_AP_MULY,
        OP_AP_WR,
        OP_MIX_DRY,
        OP_MIX_WET,
        OP_MIX_OUT
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COMB_MUL,
        ST_COMB_WR,
        ST_AVG,
        ST_AP_MULX,
        ST_AP_SUB,
        ST_AP_MULY,
        ST_AP_WR,
        ST_MIX_DRY,
        ST_MIX_WET,
        ST_MIX_OUT
    } state_t;

    typedef struct packed {
        op_t                 op;
        logic [LINE_BITS-1:0] line;
        logic [PTR_BITS-1:0]  clr_addr;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [16:0]        delay_scale;
        logic [16:0]        wet_mix;
        logic signed [15:0] comb_gain_a;
        logic signed [15:0] comb_gain_b;
        logic signed [15:0] comb_gain_c;
        logic signed [15:0] comb_gain_d;
        logic [14:0]        allpass_gain;
    } cfg_t;

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SAT_BITS-1:0] x);
        logic signed [SAT_BITS-1:0] hi;
        logic signed [SAT_BITS-1:0] lo;
        hi = SAT_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
        lo = -hi - SAT_BITS'(1);
        if (x > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (x < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return x[SAMPLE_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/srv_ctrl.sv =====
// Sequencer of the reverb core: clearing pass, then per-request step sequence.
`default_nettype none
module srv_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire srv_pkg::status_t status,
    output srv_pkg::cmd_t         cmd
);

    srv_pkg::state_t state_reg, state_next;
    logic [srv_pkg::LINE_BITS-1:0] line_reg, line_next;
    logic [srv_pkg::PTR_BITS-1:0]  clr_reg, clr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srv_pkg::ST_CLEAR;
            line_reg  <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            line_reg  <= line_next;
            clr_reg   <= clr_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        line_next    = line_reg;
        clr_next     = clr_reg;
        s_ready      = 1'b0;
        cmd.op       = srv_pkg::OP_NONE;
        cmd.line     = line_reg;
        cmd.clr_addr = clr_reg;
        unique case (state_reg)
            srv_pkg::ST_CLEAR: begin
                cmd.op   = srv_pkg::OP_CLEAR;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == srv_pkg::PTR_BITS'(srv_pkg::CLEAR_LEN - 1)) begin
                    state_next = srv_pkg::ST_IDLE;
                end
            end
            srv_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = srv_pkg::OP_LOAD;
                    line_next  = '0;
                    state_next = srv_pkg::ST_COMB_MUL;
                end
            end
            srv_pkg::ST_COMB_MUL: begin
                cmd.op     = srv_pkg::OP_COMB_MUL;
                state_next = srv_pkg::ST_COMB_WR;
            end
            srv_pkg::ST_COMB_WR: begin
                cmd.op    = srv_pkg::OP_COMB_WR;
                line_next = line_reg + 1'b1;
                if (line_reg == srv_pkg::LINE_BITS'(srv_pkg::NUM_COMBS - 1)) begin
                    state_next = srv_pkg::ST_AVG;
                end else begin
                    state_next = srv_pkg::ST_COMB_MUL;
                end
            end
            srv_pkg::ST_AVG: begin
                cmd.op     = srv_pkg::OP_AVG;
                state_next = srv_pkg::ST_AP_MULX;
            end
            srv_pkg::ST_AP_MULX: begin
                cmd.op     = srv_pkg::OP_AP_MULX;
                state_next = srv_pkg::ST_AP_SUB;
            end
            srv_pkg::ST_AP_SUB: begin
                cmd.op     = srv_pkg::OP_AP_SUB;
                state_next = srv_pkg::ST_AP_MULY;
            end
            srv_pkg::ST_AP_MULY: begin
                cmd.op     = srv_pkg::OP_AP_MULY;
                state_next = srv_pkg::ST_AP_WR;
            end
            srv_pkg::ST_AP_WR: begin
                cmd.op    = srv_pkg::OP_AP_WR;
                line_next = line_reg + 1'b1;
                if (line_reg == srv_pkg::LINE_BITS'(srv_pkg::NUM_LINES - 1)) begin
                    state_next = srv_pkg::ST_MIX_DRY;
                end else begin
                    state_next = srv_pkg::ST_AP_MULX;
                end
            end
            srv_pkg::ST_MIX_DRY: begin
                cmd.op     = srv_pkg::OP_MIX_DRY;
                state_next = srv_pkg::ST_MIX_WET;
            end
            srv_pkg::ST_MIX_WET: begin
                cmd.op     = srv_pkg::OP_MIX_WET;
                state_next = srv_pkg::ST_MIX_OUT;
            end
            srv_pkg::ST_MIX_OUT: begin
                // hold the final sum until the output register frees up
                if (status.out_free) begin
                    cmd.op     = srv_pkg::OP_MIX_OUT;
                    state_next = srv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = srv_pkg::ST_IDLE;
            end
        endcase
    end

    a_load_starts_combs: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == srv_pkg::OP_LOAD |=> state_reg == srv_pkg::ST_COMB_MUL && line_reg == '0)
        else $error("request did not start at first comb line");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == srv_pkg::ST_CLEAR |-> !s_ready)
        else $error("request accepted during memory clear");

    a_allpass_line_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == srv_pkg::ST_AP_WR) |->
        line_reg >= srv_pkg::LINE_BITS'(srv_pkg::NUM_COMBS))
        else $error("allpass step on a comb line");

endmodule
`default_nettype wire

// ===== sv/srv_datapath.sv =====
// Delay memories, pointers, shared multiplier and result register of the reverb core.
`default_nettype none
module srv_datapath (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire srv_pkg::cmd_t                          cmd,
    output srv_pkg::status_t                            status,
    input  wire srv_pkg::cfg_t                          cfg,
    input  wire logic signed [srv_pkg::SAMPLE_BITS-1:0] s_sample_in,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [srv_pkg::SAMPLE_BITS-1:0]      m_sample_out
);

    localparam int SB = srv_pkg::SAMPLE_BITS;
    localparam int NL = srv_pkg::NUM_LINES;
    localparam int PB = srv_pkg::PTR_BITS;
    localparam int WB = srv_pkg::SAT_BITS;

    logic [PB-1:0]        ptr_reg [NL];
    logic [PB-1:0]        len_reg [NL];
    logic signed [SB-1:0] rd_reg  [NL];

    logic signed [SB-1:0] dry_reg, w_reg, y_reg, out_reg;
    logic signed [SB+1:0] sum_reg;
    logic signed [42:0]   prod_reg, acc_reg;
    logic                 out_valid_reg;

    logic [16:0]          scale, wet;
    logic signed [24:0]   mul_a;
    logic signed [17:0]   mul_b;
    logic                 mul_en;
    logic signed [42:0]   q15_full;
    logic signed [WB-1:0] q15;
    logic signed [43:0]   mix_full;
    logic signed [SB-1:0] wval;
    logic signed [SB-1:0] rd_cur;
    logic signed [15:0]   gain_cur;
    logic                 line_wr;
    logic [PB:0]          ptr_inc;

    assign scale = (cfg.delay_scale > srv_pkg::ONE_Q16) ? srv_pkg::ONE_Q16 : cfg.delay_scale;
    assign wet   = (cfg.wet_mix > srv_pkg::ONE_Q16) ? srv_pkg::ONE_Q16 : cfg.wet_mix;

    // active lengths are registered from the clamped delay scale
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NL; i++) begin
            logic [28:0] lp;
            lp = 29'(scale) * 29'(srv_pkg::LINE_DEPTH[i]);
            len_reg[i] <= (lp[27:16] == '0) ? PB'(1) : lp[27:16];
        end
    end

    assign rd_cur = rd_reg[cmd.line];

    always_comb begin
        unique case (cmd.line[1:0])
            2'd0:    gain_cur = cfg.comb_gain_a;
            2'd1:    gain_cur = cfg.comb_gain_b;
            2'd2:    gain_cur = cfg.comb_gain_c;
            default: gain_cur = cfg.comb_gain_d;
        endcase
    end

    always_comb begin
        mul_en = 1'b1;
        mul_a  = 25'(rd_cur);
        mul_b  = 18'(gain_cur);
        unique case (cmd.op)
            srv_pkg::OP_COMB_MUL: begin
                mul_a = 25'(rd_cur);
                mul_b = 18'(gain_cur);
            end
            srv_pkg::OP_AP_MULX: begin
                mul_a = 25'(w_reg);
                mul_b = $signed({3'b000, cfg.allpass_gain});
            end
            srv_pkg::OP_AP_MULY: begin
                mul_a = 25'(y_reg);
                mul_b = $signed({3'b000, cfg.allpass_gain});
            end
            srv_pkg::OP_MIX_DRY: begin
                mul_a = 25'(dry_reg);
                mul_b = $signed({1'b0, srv_pkg::ONE_Q16 - wet});
            end
            srv_pkg::OP_MIX_WET: begin
                mul_a = 25'(w_reg);
                mul_b = $signed({1'b0, wet});
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign q15_full = (prod_reg + 43'sd16384) >>> 15;
    assign q15      = WB'(q15_full);
    assign mix_full = (44'(acc_reg) + 44'(prod_reg) + 44'sd32768) >>> 16;

    always_comb begin
        if (cmd.op == srv_pkg::OP_AP_WR) begin
            wval = srv_pkg::sat(q15 + WB'(w_reg));
        end else begin
            wval = srv_pkg::sat(q15 + WB'(dry_reg));
        end
    end

    assign line_wr = (cmd.op == srv_pkg::OP_COMB_WR) || (cmd.op == srv_pkg::OP_AP_WR);
    assign ptr_inc = {1'b0, ptr_reg[cmd.line]} + 1'b1;
    assign status.out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        unique case (cmd.op)
            srv_pkg::OP_LOAD: begin
                dry_reg <= s_sample_in;
                sum_reg <= '0;
            end
            srv_pkg::OP_COMB_WR: sum_reg <= sum_reg + (SB+2)'(rd_cur);
            srv_pkg::OP_AVG:     w_reg <= srv_pkg::sat(WB'((sum_reg + (SB+2)'(2)) >>> 2));
            srv_pkg::OP_AP_SUB:  y_reg <= srv_pkg::sat(WB'(rd_cur) - q15);
            srv_pkg::OP_AP_WR:   w_reg <= y_reg;
            srv_pkg::OP_MIX_WET: acc_reg <= prod_reg;
            srv_pkg::OP_MIX_OUT: out_reg <= srv_pkg::sat(WB'(mix_full));
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NL; i++) begin
                ptr_reg[i] <= '0;
            end
        end else begin
            if (cmd.op == srv_pkg::OP_MIX_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (line_wr) begin
                ptr_reg[cmd.line] <= (ptr_inc >= {1'b0, len_reg[cmd.line]}) ? '0 : ptr_inc[PB-1:0];
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_reg;

    for (genvar i = 0; i < NL; i++) begin : g_line
        localparam int Depth    = srv_pkg::LINE_DEPTH[i];
        localparam int AddrBits = $clog2(Depth);

        logic signed [SB-1:0] mem [Depth];
        logic                 we;
        logic [AddrBits-1:0]  waddr;
        logic signed [SB-1:0] wdata;

        always_comb begin
            if (cmd.op == srv_pkg::OP_CLEAR) begin
                we    = cmd.clr_addr < PB'(Depth);
                waddr = cmd.clr_addr[AddrBits-1:0];
                wdata = '0;
            end else begin
                we    = line_wr && (cmd.line == srv_pkg::LINE_BITS'(i));
                waddr = ptr_reg[i][AddrBits-1:0];
                wdata = wval;
            end
        end

        always_ff @(posedge aclk) begin
            if (we) begin
                mem[waddr] <= wdata;
            end
            rd_reg[i] <= mem[ptr_reg[i][AddrBits-1:0]];
        end

        a_ptr_in_mem: assert property (@(posedge aclk) disable iff (!aresetn)
            ptr_reg[i] < PB'(Depth))
            else $error("line pointer outside its memory");
    end

    a_out_not_overwritten: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == srv_pkg::OP_MIX_OUT |-> (!out_valid_reg || m_ready))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== sv/schroeder_reverb_core.sv =====
// Top level of the Schroeder reverb core: configuration registers and block wiring.
// One request in, one reverberated sample out. After reset the delay memories are cleared
// with s_ready low (configuration writes are taken meanwhile). Each accepted sample then
// passes four comb lines (multiply, write) and three allpass stages (multiply x, subtract,
// multiply y, write), all through one shared 25x18 multiplier, plus an averaging step and a
// dry/wet mix (dry product, wet product, output) before it reaches the result register. A new
// request is taken once the previous one has reached the result register; the result waits
// there until m_ready, and a result still waiting there holds the next one in its last mix
// step. Configuration writes are only valid while the core is idle.
`default_nettype none
module schroeder_reverb_core (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        cfg_valid,
    output logic                                             cfg_ready,
    input  wire logic [srv_pkg::CFG_IDX_BITS-1:0]            cfg_index,
    input  wire logic [srv_pkg::CFG_DATA_BITS-1:0]           cfg_data,
    input  wire logic                                        s_valid,
    output logic                                             s_ready,
    input  wire logic signed [srv_pkg::SAMPLE_BITS-1:0]      s_sample_in,
    output logic                                             m_valid,
    input  wire logic                                        m_ready,
    output logic signed [srv_pkg::SAMPLE_BITS-1:0]           m_sample_out
);

    srv_pkg::cfg_t    cfg_reg;
    srv_pkg::cmd_t    cmd;
    srv_pkg::status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay_scale  <= 17'd65536;
            cfg_reg.wet_mix      <= 17'd32768;
            cfg_reg.comb_gain_a  <= -16'sd26378;
            cfg_reg.comb_gain_b  <= -16'sd27099;
            cfg_reg.comb_gain_c  <= -16'sd25657;
            cfg_reg.comb_gain_d  <= -16'sd25035;
            cfg_reg.allpass_gain <= 15'd22938;
        end else if (cfg_valid) begin
            unique case (srv_pkg::cfg_idx_t'(cfg_index))
                srv_pkg::CFG_DELAY_SCALE: cfg_reg.delay_scale  <= cfg_data;
                srv_pkg::CFG_WET_MIX:     cfg_reg.wet_mix      <= cfg_data;
                srv_pkg::CFG_COMB_GAIN_A: cfg_reg.comb_gain_a  <= cfg_data[15:0];
                srv_pkg::CFG_COMB_GAIN_B: cfg_reg.comb_gain_b  <= cfg_data[15:0];
                srv_pkg::CFG_COMB_GAIN_C: cfg_reg.comb_gain_c  <= cfg_data[15:0];
                srv_pkg::CFG_COMB_GAIN_D: cfg_reg.comb_gain_d  <= cfg_data[15:0];
                srv_pkg::CFG_AP_GAIN:     cfg_reg.allpass_gain <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    srv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    srv_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg_reg),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

endmodule
`default_nettype wire

// ===== tb/schroeder_reverb_core_test.sv =====
// Self-checking testbench of the Schroeder reverb core: directed table, then random traffic.
`timescale 1ns / 100ps
`default_nettype none
module schroeder_reverb_core_test;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 60;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [srv_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [srv_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [srv_pkg::SAMPLE_BITS-1:0] s_sample_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [srv_pkg::SAMPLE_BITS-1:0] m_sample_out;

    schroeder_reverb_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample_in(s_sample_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_sample_out(m_sample_out)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic [16:0] p_scale, p_wet;
    logic signed [15:0] p_cgain [srv_pkg::NUM_COMBS];
    logic [14:0] p_again;
    logic signed [srv_pkg::SAMPLE_BITS-1:0] comb_line [srv_pkg::NUM_COMBS][2246];
    logic signed [srv_pkg::SAMPLE_BITS-1:0] ap_line [3][250];
    int unsigned line_ptr [srv_pkg::NUM_LINES];

    logic signed [srv_pkg::SAMPLE_BITS-1:0] expected_samples [$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int idle_phase = 0;      // 0 none, 1 sender, 2 receiver, 3 both
    bit hold_off = 0;
    int stall_cycles = 0;

    function automatic longint rshift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic logic signed [srv_pkg::SAMPLE_BITS-1:0] clip24(longint x);
        if (x > 64'sd8388607) return 24'sh7fffff;
        if (x < -64'sd8388608) return 24'sh800000;
        return x[srv_pkg::SAMPLE_BITS-1:0];
    endfunction

    function automatic longint q15(longint a, longint g);
        return rshift(a * g + 16384, 15);
    endfunction

    function automatic int unsigned line_len(int full);
        longint s, n;
        s = (p_scale > srv_pkg::ONE_Q16) ? 65536 : p_scale;
        n = (s * full) >>> 16;
        return (n == 0) ? 1 : int'(n);
    endfunction

    function automatic void step_ptr(int idx);
        int unsigned nxt;
        nxt = line_ptr[idx] + 1;
        line_ptr[idx] = (nxt >= line_len(srv_pkg::LINE_DEPTH[idx])) ? 0 : nxt;
    endfunction

    function automatic logic signed [srv_pkg::SAMPLE_BITS-1:0] reverb_predict(
            logic signed [srv_pkg::SAMPLE_BITS-1:0] dry);
        longint sum, m, mixed, w, y;
        int unsigned p;
        sum = 0;
        for (int c = 0; c < srv_pkg::NUM_COMBS; c++) begin
            p = line_ptr[c];
            if (p >= srv_pkg::LINE_DEPTH[c]) p = 0;
            sum += comb_line[c][p];
            comb_line[c][p] = clip24(q15(comb_line[c][p], p_cgain[c]) + dry);
            line_ptr[c] = p;
            step_ptr(c);
        end
        w = clip24(rshift(sum + 2, 2));
        for (int a = 0; a < 3; a++) begin
            p = line_ptr[srv_pkg::NUM_COMBS + a];
            if (p >= srv_pkg::LINE_DEPTH[srv_pkg::NUM_COMBS + a]) p = 0;
            y = clip24(longint'(ap_line[a][p]) - q15(w, p_again));
            ap_line[a][p] = clip24(q15(y, p_again) + w);
            line_ptr[srv_pkg::NUM_COMBS + a] = p;
            step_ptr(srv_pkg::NUM_COMBS + a);
            w = y;
        end
        m = (p_wet > srv_pkg::ONE_Q16) ? 65536 : p_wet;
        mixed = rshift((65536 - m) * dry + m * w + 32768, 16);
        return clip24(mixed);
    endfunction

    task automatic write_reg(srv_pkg::cfg_idx_t idx, logic [srv_pkg::CFG_DATA_BITS-1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            srv_pkg::CFG_DELAY_SCALE: p_scale = val;
            srv_pkg::CFG_WET_MIX:     p_wet = val;
            srv_pkg::CFG_COMB_GAIN_A: p_cgain[0] = val[15:0];
            srv_pkg::CFG_COMB_GAIN_B: p_cgain[1] = val[15:0];
            srv_pkg::CFG_COMB_GAIN_C: p_cgain[2] = val[15:0];
            srv_pkg::CFG_COMB_GAIN_D: p_cgain[3] = val[15:0];
            srv_pkg::CFG_AP_GAIN:     p_again = val[14:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // push one sample; a typed expectation overrides the predictor's value check
    task automatic send_sample(logic signed [srv_pkg::SAMPLE_BITS-1:0] x, bit typed,
            logic signed [srv_pkg::SAMPLE_BITS-1:0] want);
        logic signed [srv_pkg::SAMPLE_BITS-1:0] pred;
        @(negedge aclk);
        if (idle_phase == 1 || idle_phase == 3) begin
            while ($urandom_range(99) < (idle_phase == 1 ? 64 : 32)) @(negedge aclk);
        end
        s_sample_in <= x;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = reverb_predict(x);
        if (typed && pred != want)
            $error("table row disagrees with predictor: sample_out expected %0d, got %0d",
                   want, pred);
        expected_samples.push_back(typed ? want : pred);
        items_sent++;
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_samples.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // receiver
    always @(negedge aclk) begin
        if (hold_off) begin
            m_ready <= 1'b0;
        end else if (idle_phase == 2) begin
            m_ready <= ($urandom_range(99) >= 64);
        end else if (idle_phase == 3) begin
            m_ready <= ($urandom_range(99) >= 32);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_samples.size() == 0) begin
                $error("unexpected result: sample_out actual %0d", m_sample_out);
                errors++;
            end else begin
                if (m_sample_out !== expected_samples[0]) begin
                    $error("sample_out mismatch: expected %0d, actual %0d",
                           expected_samples[0], m_sample_out);
                    errors++;
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    // watchdog on cycles without any handshake on the request, result or configuration port
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("Mismatches found");
                $finish;
            end
        end
    end

    typedef struct {
        logic signed [srv_pkg::SAMPLE_BITS-1:0] x;
        bit typed;
        logic signed [srv_pkg::SAMPLE_BITS-1:0] want;
    } row_t;

    task automatic random_block(int count);
        int kind;
        logic signed [srv_pkg::SAMPLE_BITS-1:0] x;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(9);
            if (kind == 0) x = 24'sh7fffff;
            else if (kind == 1) x = 24'sh800000;
            else if (kind < 5) x = srv_pkg::SAMPLE_BITS'($urandom_range(2000) - 1000);
            else x = srv_pkg::SAMPLE_BITS'($urandom);
            send_sample(x, 0, '0);
        end
    endtask

    task automatic random_config();
        logic [16:0] v;
        v = ($urandom_range(3) == 0) ? 17'(17'd65536 + $urandom_range(65535)) :
                                       17'($urandom_range(65536));
        write_reg(srv_pkg::CFG_DELAY_SCALE,
                  ($urandom_range(2) == 0) ? 17'($urandom_range(300)) : v);
        write_reg(srv_pkg::CFG_WET_MIX, 17'($urandom));
        write_reg(srv_pkg::CFG_COMB_GAIN_A, 17'($urandom));
        write_reg(srv_pkg::CFG_COMB_GAIN_B, 17'($urandom));
        write_reg(srv_pkg::CFG_COMB_GAIN_C, 17'($urandom));
        write_reg(srv_pkg::CFG_COMB_GAIN_D, 17'($urandom));
        write_reg(srv_pkg::CFG_AP_GAIN, 17'($urandom_range(32767)));
    endtask

    row_t dir_rows [$];

    initial begin
        p_scale = 17'd65536;
        p_wet = 17'd32768;
        p_cgain[0] = -16'sd26378;
        p_cgain[1] = -16'sd27099;
        p_cgain[2] = -16'sd25657;
        p_cgain[3] = -16'sd25035;
        p_again = 15'd22938;
        for (int c = 0; c < srv_pkg::NUM_COMBS; c++)
            for (int k = 0; k < 2246; k++) comb_line[c][k] = '0;
        for (int a = 0; a < 3; a++)
            for (int k = 0; k < 250; k++) ap_line[a][k] = '0;
        for (int l = 0; l < srv_pkg::NUM_LINES; l++) line_ptr[l] = 0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // after reset the delay lines are empty: output is dry*(1/2), rounded half up
        dir_rows.push_back('{24'sh7fffff, 1, 24'sd4194304});
        dir_rows.push_back('{24'sh000000, 1, 24'sd0});
        dir_rows.push_back('{24'sh800000, 0, 0});
        dir_rows.push_back('{24'sd1, 0, 0});
        dir_rows.push_back('{-24'sd1, 0, 0});
        foreach (dir_rows[i]) send_sample(dir_rows[i].x, dir_rows[i].typed, dir_rows[i].want);
        drain();

        // dry only
        write_reg(srv_pkg::CFG_WET_MIX, 17'd0);
        send_sample(24'sh800000, 1, 24'sh800000);
        send_sample(24'sd12345, 1, 24'sd12345);
        drain();
        // scale and wet above one, full gains
        write_reg(srv_pkg::CFG_DELAY_SCALE, 17'h1ffff);
        write_reg(srv_pkg::CFG_WET_MIX, 17'h1ffff);
        write_reg(srv_pkg::CFG_COMB_GAIN_A, 17'h07fff);
        write_reg(srv_pkg::CFG_COMB_GAIN_B, 17'h08000);
        write_reg(srv_pkg::CFG_COMB_GAIN_C, 17'h07fff);
        write_reg(srv_pkg::CFG_COMB_GAIN_D, 17'h08000);
        write_reg(srv_pkg::CFG_AP_GAIN, 17'h07fff);
        for (int i = 0; i < 6; i++) send_sample(i[0] ? 24'sh7fffff : 24'sh800000, 0, 0);
        drain();
        // shrink to the minimum length of one while pointers sit beyond it
        write_reg(srv_pkg::CFG_DELAY_SCALE, 17'd0);
        write_reg(srv_pkg::CFG_AP_GAIN, 17'd0);
        for (int i = 0; i < 6; i++) send_sample(srv_pkg::SAMPLE_BITS'(24'sh400000 - i), 0, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            idle_phase = ph % 4;
            random_config();
            random_block(220);
            if (ph == 2) begin
                // receiver holds off while sender keeps offering
                hold_off = 1;
                fork
                    random_block(6);
                    begin
                        repeat (400) @(negedge aclk);
                        hold_off = 0;
                    end
                join
            end
            drain();
        end
        idle_phase = 0;
        random_block(60);
        drain();

        $display("Sent %0d samples over several register settings and idle patterns, %0d checked.",
                 items_sent, results_seen);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/srv_pkg.sv
sv/srv_ctrl.sv
sv/srv_datapath.sv
sv/schroeder_reverb_core.sv
tb/schroeder_reverb_core_test.sv
